// ===== rtl/assert_macros.svh =====
// Assertion macros for the RTL. Empty under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define QMB_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("qmb assertion failed");
`define QMB_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("qmb assertion failed");
`else
`define QMB_ASSERT(lbl, clk, rst, prop)
`define QMB_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== rtl/qmb_pkg.sv =====
// ----------------------------------------------------------------------------
// qmb_pkg
// Types, codes and geometry helper for the quadtree mass binning block.
// ----------------------------------------------------------------------------
`default_nettype none

package qmb_pkg;

  localparam int NODE_TOTAL    = 21845;
  localparam int MAX_PARTICLES = 4096;
  localparam logic [2:0] DEPTH_LIMIT = 3'd7;

  typedef enum logic [1:0] {
    OP_INSERT  = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_SUMMARY = 2'd2,
    OP_READ    = 2'd3
  } op_t;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_DROP   = 2'd1;
  localparam logic [1:0] ST_BADIDX = 2'd2;

  localparam logic [1:0] REG_AREA_WIDTH    = 2'd0;
  localparam logic [1:0] REG_AREA_HEIGHT   = 2'd1;
  localparam logic [1:0] REG_SPLIT_DEPTH   = 2'd2;
  localparam logic [1:0] REG_NODE_CAPACITY = 2'd3;

  typedef struct packed {
    logic        split;
    logic [12:0] count;
    logic [12:0] head;
    logic [27:0] mass;
    logic [43:0] mx;
    logic [43:0] my;
  } node_t;

  typedef struct packed {
    logic [12:0] next;
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] m;
  } elem_t;

  // {hit, upper half} for point p against halves [o,o+c) and [o+c,o+2c)
  function automatic logic [1:0] pick_half(input logic [23:0] p, input logic [23:0] o,
                                           input logic [23:0] c);
    logic [25:0] pp, lo, mid, top;
    logic        in_lo, in_hi;
    begin
      pp    = {2'b00, p};
      lo    = {2'b00, o};
      mid   = lo + {2'b00, c};
      top   = mid + {2'b00, c};
      in_lo = (pp >= lo) && (pp < mid);
      in_hi = (pp >= mid) && (pp < top);
      return {in_lo | in_hi, in_hi};
    end
  endfunction

endpackage

`default_nettype wire

// ===== rtl/quadtree_mass_binning.sv =====
// ----------------------------------------------------------------------------
// quadtree_mass_binning
// Implicit quadtree builder with per-node mass and moment sums.
// ----------------------------------------------------------------------------
// Input words arrive on s_axis: tuser carries the operation, tdata the
// particle position, mass and node index. Every input word gives exactly one
// result word on m_axis. Registers are written on the cfg channel, which is
// always ready; write them only while the block is idle.
// Insert walks the tree level by level (node memory read, decide, descend),
// and every leaf that splits on the way down moves its listed particles
// into its children; an insert that lands in the root answers without
// descending, and a full store drops it without walking the tree.
// Summary runs two 16-step dividers for the center of mass and skips them
// when the total mass is zero; running totals are kept on every update.
// Clear, and reset, sweep all 21845 node memory entries one entry a cycle
// with s_axis_tready low; clear then returns a status word.
// One word is worked on at a time; the next is taken while the result still
// sits in the output register. A stalled receiver holds m_axis_tdata and
// stops the block once a second result is ready.
`default_nettype none

`include "assert_macros.svh"

module quadtree_mass_binning import qmb_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output      logic         s_axis_tready,
  // pos_x[15:0], pos_y[31:16], mass[47:32], node_index[62:48], zero pad
  input  wire logic [63:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output      logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // status[1:0], leaf_index[16:2], is_internal[17], count[30:18],
  // mass_sum[58:31], moment_x[102:59], moment_y[146:103], com_x[162:147],
  // com_y[178:163], leaf_total[193:179], zero pad
  output      logic [199:0] m_axis_tdata,
  input  wire logic         cfg_valid,
  output      logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [11:0]  cfg_data
);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_WWAIT, S_WUSE, S_DESC, S_EWAIT, S_EUSE,
    S_CWAIT, S_CUSE, S_NEXT, S_RWAIT, S_RUSE, S_DIV, S_FIN
  } state_t;

  state_t state;

  node_t node_mem [NODE_TOTAL];
  elem_t elem_mem [MAX_PARTICLES];
  node_t nd_q;
  elem_t el_q;
  logic [14:0] na;
  logic [11:0] ea;

  logic        nw_en, ew_en;
  logic [14:0] nw_addr;
  logic [11:0] ew_addr;
  node_t       nw_data;
  elem_t       ew_data;

  logic [11:0] area_width, area_height;
  logic [2:0]  split_depth;
  logic [6:0]  node_capacity;

  logic [15:0] in_x, in_y, in_m;
  logic [31:0] ipx, ipy, epx, epy;
  logic [14:0] idx;
  logic [2:0]  d;
  logic [23:0] ox, oy, sw, sh;
  logic [12:0] ins_total;
  logic [27:0] gm;
  logic [43:0] gx, gy;
  logic [14:0] leaves;
  logic [14:0] cc;
  logic        clr_reply;
  logic [12:0] sp_n;
  logic [11:0] sp_nxt;
  logic [11:0] sp_cur;
  elem_t       sp_el;
  logic [43:0] dr_x, dr_y;
  logic [3:0]  dbit;

  logic [1:0]  r_status;
  logic [14:0] r_leaf;
  logic        r_int;
  logic [12:0] r_count;
  logic [27:0] r_mass;
  logic [43:0] r_mx, r_my;
  logic [15:0] r_cx, r_cy;
  logic [14:0] r_lt;

  logic        w_split, w_add;
  logic [1:0]  hx, hy, ehx, ehy;
  logic [1:0]  j_in, j_el;
  logic [14:0] child_in, child_el;
  logic [43:0] div_x, div_y;

  assign s_axis_tready = (state == S_IDLE);
  assign cfg_ready     = 1'b1;

  assign w_split = !nd_q.split && (d < split_depth) &&
                   (({1'b0, nd_q.count} + 14'd1) > {7'd0, node_capacity});
  assign w_add   = !nd_q.split && !w_split;

  assign hx  = pick_half({in_x, 8'd0}, ox, {1'b0, sw[23:1]});
  assign hy  = pick_half({in_y, 8'd0}, oy, {1'b0, sh[23:1]});
  assign ehx = pick_half({el_q.x, 8'd0}, ox, {1'b0, sw[23:1]});
  assign ehy = pick_half({el_q.y, 8'd0}, oy, {1'b0, sh[23:1]});
  assign j_in = {hy[0], hx[0]};
  assign j_el = {ehy[0], ehx[0]};
  assign child_in = {idx[12:0], 2'b00} + 15'd1 + {13'd0, j_in};
  assign child_el = {idx[12:0], 2'b00} + 15'd1 + {13'd0, j_el};

  assign div_x = {16'd0, gm} << dbit;
  assign div_y = {16'd0, gm} << dbit;

  always_comb begin
    nw_en   = 1'b0;
    nw_addr = idx;
    nw_data = '0;
    ew_en   = 1'b0;
    ew_addr = ins_total[11:0];
    ew_data = '{next: nd_q.head, x: in_x, y: in_y, m: in_m};
    case (state)
      S_CLR: begin
        nw_en   = 1'b1;
        nw_addr = cc;
      end
      S_WUSE: begin
        if (w_split) begin
          nw_en       = 1'b1;
          nw_data.split = 1'b1;
        end else if (w_add) begin
          nw_en   = 1'b1;
          nw_data = '{split: 1'b0, count: nd_q.count + 13'd1, head: ins_total,
                      mass: nd_q.mass + {12'd0, in_m},
                      mx: nd_q.mx + {12'd0, ipx}, my: nd_q.my + {12'd0, ipy}};
          ew_en   = 1'b1;
        end
      end
      S_CUSE: begin
        nw_en   = 1'b1;
        nw_addr = na;
        nw_data = '{split: 1'b0, count: nd_q.count + 13'd1, head: {1'b0, sp_cur},
                    mass: nd_q.mass + {12'd0, sp_el.m},
                    mx: nd_q.mx + {12'd0, epx}, my: nd_q.my + {12'd0, epy}};
        ew_en   = 1'b1;
        ew_addr = sp_cur;
        ew_data = '{next: nd_q.head, x: sp_el.x, y: sp_el.y, m: sp_el.m};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (nw_en) begin
      node_mem[nw_addr] <= nw_data;
    end
    nd_q <= node_mem[na];
  end

  always_ff @(posedge clk) begin
    if (ew_en) begin
      elem_mem[ew_addr] <= ew_data;
    end
    el_q <= elem_mem[ea];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_width    <= 12'd1920;
      area_height   <= 12'd1080;
      split_depth   <= 3'd7;
      node_capacity <= 7'd4;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AREA_WIDTH:    area_width    <= cfg_data;
        REG_AREA_HEIGHT:   area_height   <= cfg_data;
        REG_SPLIT_DEPTH:   split_depth   <= cfg_data[2:0];
        REG_NODE_CAPACITY: node_capacity <= cfg_data[6:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      cc            <= '0;
      clr_reply     <= 1'b0;
      ins_total     <= '0;
      gm            <= '0;
      gx            <= '0;
      gy            <= '0;
      leaves        <= 15'd1;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_FIN) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          cc <= cc + 15'd1;
          if (cc == 15'(NODE_TOTAL - 1)) begin
            state <= clr_reply ? S_FIN : S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            in_x     <= s_axis_tdata[15:0];
            in_y     <= s_axis_tdata[31:16];
            in_m     <= s_axis_tdata[47:32];
            ipx      <= s_axis_tdata[47:32] * s_axis_tdata[15:0];
            ipy      <= s_axis_tdata[47:32] * s_axis_tdata[31:16];
            r_leaf   <= '0;
            r_int    <= 1'b0;
            r_count  <= '0;
            r_cx     <= '0;
            r_cy     <= '0;
            case (op_t'(s_axis_tuser))
              OP_INSERT: begin
                r_mass <= '0;
                r_mx   <= '0;
                r_my   <= '0;
                r_lt   <= '0;
                idx    <= '0;
                d      <= '0;
                ox     <= '0;
                oy     <= '0;
                sw     <= {area_width, 12'd0};
                sh     <= {area_height, 12'd0};
                na     <= '0;
                if (ins_total[12]) begin
                  r_status <= ST_DROP;
                  state    <= S_FIN;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_WWAIT;
                end
              end
              OP_CLEAR: begin
                r_status  <= ST_OK;
                r_mass    <= '0;
                r_mx      <= '0;
                r_my      <= '0;
                r_lt      <= '0;
                cc        <= '0;
                clr_reply <= 1'b1;
                ins_total <= '0;
                gm        <= '0;
                gx        <= '0;
                gy        <= '0;
                leaves    <= 15'd1;
                state     <= S_CLR;
              end
              OP_SUMMARY: begin
                r_status <= ST_OK;
                r_mass   <= gm;
                r_mx     <= gx;
                r_my     <= gy;
                r_lt     <= leaves;
                dr_x     <= gx;
                dr_y     <= gy;
                dbit     <= 4'd15;
                state    <= (gm == '0) ? S_FIN : S_DIV;
              end
              OP_READ: begin
                r_mass <= '0;
                r_mx   <= '0;
                r_my   <= '0;
                r_lt   <= '0;
                na     <= s_axis_tdata[62:48];
                if (s_axis_tdata[62:48] >= 15'(NODE_TOTAL)) begin
                  r_status <= ST_BADIDX;
                  state    <= S_FIN;
                end else begin
                  r_status <= ST_OK;
                  state    <= S_RWAIT;
                end
              end
              default: begin
                r_status <= ST_OK;
                r_mass   <= '0;
                r_mx     <= '0;
                r_my     <= '0;
                r_lt     <= '0;
                state    <= S_FIN;
              end
            endcase
          end
        end
        S_WWAIT: state <= S_WUSE;
        S_WUSE: begin
          if (w_split) begin
            sp_n   <= nd_q.count;
            ea     <= nd_q.head[11:0];
            gm     <= gm - nd_q.mass;
            gx     <= gx - nd_q.mx;
            gy     <= gy - nd_q.my;
            leaves <= leaves + 15'd3;
            state  <= (nd_q.count == '0) ? S_DESC : S_EWAIT;
          end else if (w_add) begin
            ins_total <= ins_total + 13'd1;
            gm        <= gm + {12'd0, in_m};
            gx        <= gx + {12'd0, ipx};
            gy        <= gy + {12'd0, ipy};
            r_leaf    <= idx;
            state     <= S_FIN;
          end else begin
            state <= S_DESC;
          end
        end
        S_DESC: begin
          if (d == DEPTH_LIMIT || !(hx[1] && hy[1])) begin
            r_status <= ST_DROP;
            state    <= S_FIN;
          end else begin
            if (hx[0]) ox <= ox + {1'b0, sw[23:1]};
            if (hy[0]) oy <= oy + {1'b0, sh[23:1]};
            sw    <= {1'b0, sw[23:1]};
            sh    <= {1'b0, sh[23:1]};
            idx   <= child_in;
            na    <= child_in;
            d     <= d + 3'd1;
            state <= S_WWAIT;
          end
        end
        S_EWAIT: state <= S_EUSE;
        S_EUSE: begin
          sp_el  <= el_q;
          sp_cur <= ea;
          sp_nxt <= el_q.next[11:0];
          epx    <= el_q.m * el_q.x;
          epy    <= el_q.m * el_q.y;
          na     <= child_el;
          state  <= (ehx[1] && ehy[1]) ? S_CWAIT : S_NEXT;
        end
        S_CWAIT: state <= S_CUSE;
        S_CUSE: begin
          gm    <= gm + {12'd0, sp_el.m};
          gx    <= gx + {12'd0, epx};
          gy    <= gy + {12'd0, epy};
          state <= S_NEXT;
        end
        S_NEXT: begin
          sp_n <= sp_n - 13'd1;
          ea   <= sp_nxt;
          state <= (sp_n == 13'd1) ? S_DESC : S_EWAIT;
        end
        S_RWAIT: state <= S_RUSE;
        S_RUSE: begin
          r_int   <= nd_q.split;
          r_count <= nd_q.count;
          r_mass  <= nd_q.mass;
          r_mx    <= nd_q.mx;
          r_my    <= nd_q.my;
          state   <= S_FIN;
        end
        S_DIV: begin
          if (dr_x >= div_x) begin
            dr_x       <= dr_x - div_x;
            r_cx[dbit] <= 1'b1;
          end
          if (dr_y >= div_y) begin
            dr_y       <= dr_y - div_y;
            r_cy[dbit] <= 1'b1;
          end
          dbit <= dbit - 4'd1;
          if (dbit == 4'd0) state <= S_FIN;
        end
        S_FIN: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {6'd0, r_lt, r_cy, r_cx, r_my, r_mx, r_mass, r_count,
                              r_int, r_leaf, r_status};
            clr_reply     <= 1'b0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `QMB_ASSERT(a_one_word, clk, rst, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
  `QMB_ASSERT(a_store_bound, clk, rst, ins_total <= 13'(MAX_PARTICLES))
  `QMB_ASSERT(a_child_leaf, clk, rst, (state == S_CUSE) |-> !nd_q.split)
  `QMB_ASSERT(a_split_depth, clk, rst, (state == S_WUSE && w_split) |-> d < DEPTH_LIMIT)

endmodule

`default_nettype wire

// ===== tb/sv/tb_quadtree_mass_binning.sv =====
// ----------------------------------------------------------------------------
// tb_quadtree_mass_binning
// Self-checking bench for the quadtree mass binning block: a queue-fed driver
// pushes operation words and register writes, a scoreboard model predicts one
// result word per input word, and a monitor compares results field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_quadtree_mass_binning import qmb_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {K_WORD, K_CFG, K_SYNC} kind_t;

  typedef struct {
    kind_t       kind;
    op_t         op;
    logic [15:0] x, y, m;
    logic [14:0] idx;
    logic [1:0]  reg_sel;
    logic [11:0] reg_val;
  } feed_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [14:0] leaf;
    logic        internal;
    logic [12:0] count;
    logic [27:0] mass;
    logic [43:0] mx, my;
    logic [15:0] cx, cy;
    logic [14:0] leaves;
  } result_t;

  logic clk, rst;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0] s_axis_tuser;
  logic [199:0] m_axis_tdata;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [11:0] cfg_data;

  quadtree_mass_binning dut (.*);

  feed_t   feed_q[$];
  result_t pending_results[$];
  feed_t   cur;
  int      errors = 0;
  int      gap = 0, stall = 0;

  // shadow tree
  int unsigned     aw, ah, depth_cfg, cap;
  bit              split_f[NODE_TOTAL];
  int unsigned     ncount[NODE_TOTAL], nhead[NODE_TOTAL];
  longint unsigned nmass[NODE_TOTAL], nmx[NODE_TOTAL], nmy[NODE_TOTAL];
  int unsigned     enext[MAX_PARTICLES], ex[MAX_PARTICLES], ey[MAX_PARTICLES];
  int unsigned     em[MAX_PARTICLES];
  int unsigned     stored, splits;
  longint unsigned sum_m, sum_mx, sum_my;

  function automatic void clear_tree();
    for (int i = 0; i < NODE_TOTAL; i++) begin
      split_f[i] = 0; ncount[i] = 0; nhead[i] = 0;
      nmass[i] = 0; nmx[i] = 0; nmy[i] = 0;
    end
    stored = 0; splits = 0; sum_m = 0; sum_mx = 0; sum_my = 0;
  endfunction

  function automatic int quadrant(longint unsigned ox, oy, cw, ch, px, py);
    longint unsigned lx, ly;
    for (int j = 0; j < 4; j++) begin
      lx = ox + ((j & 1) ? cw : 0);
      ly = oy + ((j & 2) ? ch : 0);
      if (px >= lx && px < lx + cw && py >= ly && py < ly + ch) return j;
    end
    return -1;
  endfunction

  function automatic void link_particle(int unsigned node, int unsigned e);
    longint unsigned mm;
    mm = em[e];
    enext[e] = nhead[node];
    nhead[node] = e;
    ncount[node]++;
    nmass[node] += mm; nmx[node] += mm * ex[e]; nmy[node] += mm * ey[e];
    sum_m += mm; sum_mx += mm * ex[e]; sum_my += mm * ey[e];
  endfunction

  function automatic void split_node(int unsigned node, longint unsigned ox, oy, cw, ch);
    int unsigned n, e, nxt;
    int j;
    n = ncount[node];
    e = nhead[node];
    sum_m -= nmass[node]; sum_mx -= nmx[node]; sum_my -= nmy[node];
    for (int i = 0; i < n; i++) begin
      if (e >= MAX_PARTICLES) break;
      nxt = enext[e];
      j = quadrant(ox, oy, cw, ch, longint'(ex[e]) << 8, longint'(ey[e]) << 8);
      if (j >= 0) link_particle(4 * node + 1 + j, e);
      e = nxt;
    end
    split_f[node] = 1; ncount[node] = 0; nhead[node] = 0;
    nmass[node] = 0; nmx[node] = 0; nmy[node] = 0;
    splits++;
  endfunction

  function automatic result_t predict_insert(logic [15:0] x, y, m);
    result_t r;
    longint unsigned px, py, ox, oy, sw, sh, cw, ch;
    int unsigned idx, d;
    int j;
    r = '0;
    px = longint'(x) << 8; py = longint'(y) << 8;
    ox = 0; oy = 0;
    sw = longint'(aw) << 12; sh = longint'(ah) << 12;
    idx = 0; d = 0;
    if (stored >= MAX_PARTICLES) begin
      r.status = ST_DROP;
      return r;
    end
    forever begin
      cw = sw >> 1; ch = sh >> 1;
      if (!split_f[idx]) begin
        if (d < depth_cfg && ncount[idx] + 1 > cap) begin
          split_node(idx, ox, oy, cw, ch);
        end else begin
          ex[stored] = x; ey[stored] = y; em[stored] = m;
          link_particle(idx, stored);
          stored++;
          r.status = ST_OK;
          r.leaf = idx[14:0];
          return r;
        end
      end
      if (d >= DEPTH_LIMIT) begin
        r.status = ST_DROP;
        return r;
      end
      j = quadrant(ox, oy, cw, ch, px, py);
      if (j < 0) begin
        r.status = ST_DROP;
        return r;
      end
      if (j & 1) ox += cw;
      if (j & 2) oy += ch;
      sw = cw; sh = ch;
      idx = 4 * idx + 1 + j;
      d++;
    end
  endfunction

  function automatic result_t predict_word(feed_t it);
    result_t r;
    r = '0;
    case (it.op)
      OP_INSERT: r = predict_insert(it.x, it.y, it.m);
      OP_CLEAR: clear_tree();
      OP_SUMMARY: begin
        r.mass = sum_m[27:0]; r.mx = sum_mx[43:0]; r.my = sum_my[43:0];
        r.cx = sum_m ? 16'(sum_mx / sum_m) : '0;
        r.cy = sum_m ? 16'(sum_my / sum_m) : '0;
        r.leaves = 15'(1 + 3 * splits);
      end
      default: begin
        if (it.idx >= NODE_TOTAL) begin
          r.status = ST_BADIDX;
        end else begin
          r.internal = split_f[it.idx];
          r.count = ncount[it.idx][12:0];
          r.mass = nmass[it.idx][27:0];
          r.mx = nmx[it.idx][43:0];
          r.my = nmy[it.idx][43:0];
        end
      end
    endcase
    return r;
  endfunction

  function automatic void apply_reg(logic [1:0] sel, logic [11:0] v);
    case (sel)
      REG_AREA_WIDTH: aw = v;
      REG_AREA_HEIGHT: ah = v;
      REG_SPLIT_DEPTH: depth_cfg = v[2:0];
      default: cap = v[6:0];
    endcase
  endfunction

  // stimulus builders
  function automatic void push_word(op_t op, logic [15:0] x = '0, y = '0, m = '0,
                                    logic [14:0] idx = '0);
    feed_t it;
    it = '{kind: K_WORD, op: op, x: x, y: y, m: m, idx: idx, reg_sel: '0, reg_val: '0};
    feed_q = {feed_q, it};
  endfunction

  function automatic void push_read(logic [14:0] idx);
    push_word(OP_READ, 16'd0, 16'd0, 16'd0, idx);
  endfunction

  function automatic void push_sync();
    feed_t it;
    it = '{kind: K_SYNC, op: OP_CLEAR, x: '0, y: '0, m: '0, idx: '0, reg_sel: '0,
           reg_val: '0};
    feed_q = {feed_q, it};
  endfunction

  function automatic void push_setup(int unsigned w, h, d, c);
    feed_t it;
    push_sync();
    it = '{kind: K_CFG, op: OP_CLEAR, x: '0, y: '0, m: '0, idx: '0,
           reg_sel: REG_AREA_WIDTH, reg_val: 12'(w)};
    feed_q = {feed_q, it};
    it.reg_sel = REG_AREA_HEIGHT; it.reg_val = 12'(h); feed_q = {feed_q, it};
    it.reg_sel = REG_SPLIT_DEPTH; it.reg_val = 12'(d); feed_q = {feed_q, it};
    it.reg_sel = REG_NODE_CAPACITY; it.reg_val = 12'(c); feed_q = {feed_q, it};
  endfunction

  function automatic logic [15:0] coord(int unsigned span, int unsigned center);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 2) return 16'($urandom);
    if (sel < 5) return 16'(center + $urandom_range(0, 7));
    if (span == 0) return 16'($urandom_range(0, 15));
    return 16'($urandom_range(0, span * 16 - 1 > 65535 ? 65535 : span * 16 - 1));
  endfunction

  function automatic void random_phase(int unsigned w, h, d, c, int n);
    int unsigned cxp, cyp, sel;
    push_setup(w, h, d, c);
    push_word(OP_CLEAR);
    cxp = $urandom_range(0, w * 16); cyp = $urandom_range(0, h * 16);
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      if (i == n / 2) push_sync();
      if (sel < 70)
        push_word(OP_INSERT, coord(w, cxp), coord(h, cyp), 16'($urandom));
      else if (sel < 85)
        push_read(15'($urandom_range(0, 340)));
      else if (sel < 90)
        push_read(15'($urandom));
      else
        push_word(OP_SUMMARY);
    end
    push_word(OP_SUMMARY);
  endfunction

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst = 1;
    s_axis_tvalid = 0; s_axis_tdata = '0; s_axis_tuser = OP_INSERT;
    cfg_valid = 0; cfg_index = REG_AREA_WIDTH; cfg_data = '0;
    m_axis_tready = 0;
    aw = 1920; ah = 1080; depth_cfg = 7; cap = 4;
    clear_tree();
    repeat (3) @(posedge clk);
    rst <= 0;
  end

  initial begin
    // directed: reset settings
    push_read(15'd0);
    push_word(OP_SUMMARY);
    push_word(OP_INSERT, 16'hFFFF, 16'hFFFF, 16'd1);     // outside, root still takes it
    push_word(OP_INSERT, 16'd0, 16'd0, 16'hFFFF);
    push_word(OP_INSERT, 16'd30719, 16'd17279, 16'd0);   // last unit inside the area
    for (int i = 0; i < 5; i++) push_word(OP_INSERT, 16'd100, 16'd100, 16'hFFFF);
    push_word(OP_INSERT, 16'd40000, 16'd100, 16'd7);    // beyond the area after split
    push_read(15'd0);
    push_read(15'd1);
    push_read(15'd21844);
    push_read(15'd21845);
    push_read(15'h7FFF);
    push_word(OP_SUMMARY);
    push_word(OP_CLEAR);
    push_word(OP_SUMMARY);
    // zero capacity: every leaf splits until the depth bottoms out
    push_setup(1920, 1080, 3, 0);
    push_word(OP_INSERT, 16'd5000, 16'd5000, 16'd3);
    push_word(OP_INSERT, 16'd5001, 16'd5000, 16'd4);
    push_word(OP_SUMMARY);
    push_read(15'd0);
    random_phase(4095, 4095, 7, 64, 200);
    random_phase(1, 1, 0, 1, 120);
    random_phase(64, 48, 7, 1, 220);
    random_phase(0, 300, 2, 2, 60);
    random_phase($urandom_range(1, 4095), $urandom_range(1, 4095), $urandom_range(0, 7),
                 $urandom_range(1, 64), 250);
    random_phase(1920, 1080, 7, 4, 450);
  end

  // driver
  always @(posedge clk) begin
    logic  nv, ncv, idle;
    feed_t it;
    nv = s_axis_tvalid;
    ncv = cfg_valid;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results = {pending_results, predict_word(cur)};
        nv = 0;
      end
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        ncv = 0;
      end
      if (!nv && !ncv) begin
        idle = pending_results.size() == 0;
        if (gap > 0) begin
          gap--;
        end else if (feed_q.size() > 0) begin
          it = feed_q[0];
          if (it.kind == K_WORD) begin
            void'(feed_q.pop_front());
            cur <= it;
            nv = 1;
            s_axis_tuser <= it.op;
            s_axis_tdata <= {1'b0, it.idx, it.m, it.y, it.x};
            if (feed_q.size() > 300 && $urandom_range(0, 5) == 0)
              gap = $urandom_range(1, 11);
          end else if (idle && s_axis_tready) begin
            void'(feed_q.pop_front());
            if (it.kind == K_CFG) begin
              ncv = 1;
              cfg_index <= it.reg_sel;
              cfg_data <= it.reg_val;
            end
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    cfg_valid <= ncv;
  end

  function automatic void check_field(string name, longint unsigned want, got);
    if (want !== got) begin
      $display("%t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // monitor
  always @(posedge clk) begin
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $display("%t unexpected result word: expected none actual %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", want.status, m_axis_tdata[1:0]);
        check_field("leaf_index", want.leaf, m_axis_tdata[16:2]);
        check_field("is_internal", want.internal, m_axis_tdata[17]);
        check_field("count", want.count, m_axis_tdata[30:18]);
        check_field("mass_sum", want.mass, m_axis_tdata[58:31]);
        check_field("moment_x", want.mx, m_axis_tdata[102:59]);
        check_field("moment_y", want.my, m_axis_tdata[146:103]);
        check_field("com_x", want.cx, m_axis_tdata[162:147]);
        check_field("com_y", want.cy, m_axis_tdata[178:163]);
        check_field("leaf_total", want.leaves, m_axis_tdata[193:179]);
      end
    end
    if (stall > 0) begin
      stall--;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      if (feed_q.size() > 300 && $urandom_range(0, 6) == 0) stall = $urandom_range(1, 11);
    end
  end

  initial begin
    @(negedge rst);
    do @(posedge clk);
    while (feed_q.size() != 0 || s_axis_tvalid || cfg_valid || pending_results.size() != 0);
    repeat (200) @(posedge clk);
    if (errors == 0 && pending_results.size() == 0)
      $display("tb_quadtree_mass_binning: clean");
    else
      $display("tb_quadtree_mass_binning: errors");
    $finish;
  end

  initial begin
    #30ms;
    $display("tb_quadtree_mass_binning: errors");
    $finish;
  end

endmodule

`default_nettype wire
